/* hw/rtl/crsh_pkg.sv */
// ----------------------------------------------------------------------------
// crsh_pkg
// Shared types, widths and helpers for the closest ray/segment hit block.
// ----------------------------------------------------------------------------
package crsh_pkg;

  localparam int COORD_W         = 16;  // target, segment and hit fields
  localparam int LIGHT_W         = 15;  // light position registers
  localparam int SCREEN_W        = 12;  // screen size registers
  localparam int CFG_DATA_W      = 15;  // widest register
  localparam int CFG_INDEX_W     = 2;
  localparam int DIFF_W          = 17;  // coordinate differences
  localparam int PROD_W          = 34;  // 17 x 17 products
  localparam int SUM_W           = 35;  // den, num1, num2
  localparam int DIST_W          = 35;
  localparam int DIV_N_W         = 54;  // dividend magnitude
  localparam int DIV_D_W         = 36;  // divisor, 2 * den
  localparam int DIV_CNT_W       = 6;
  localparam int QSAT_W          = 18;  // saturated quotient magnitude
  localparam int LIM_W           = 21;  // screen limit before saturation
  localparam int COORD_FRAC_BITS = 4;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_LIGHT_X       = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_LIGHT_Y       = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_WIDTH  = 2'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_SCREEN_HEIGHT = 2'd3;

  // one classified segment, front to back
  typedef struct packed {
    logic                      hit;
    logic                      last;
    logic [SUM_W-1:0]          num1;
    logic [SUM_W-1:0]          den;
    logic signed [DIFF_W-1:0]  dx;
    logic signed [DIFF_W-1:0]  dy;
    logic signed [COORD_W-1:0] tx;
    logic signed [COORD_W-1:0] ty;
  } seg_entry_t;

  typedef struct packed {
    logic valid;
    logic full;
  } q_stat_t;

  typedef enum logic [3:0] {
    B_IDLE, B_MULX, B_DIVX, B_MULY, B_DIVY, B_CLAMP, B_SQUARE, B_UPDATE, B_EMIT
  } back_state_t;

  // largest hit coordinate for a screen size in pixels
  function automatic logic [LIGHT_W-1:0] screen_limit(input logic [SCREEN_W-1:0] pixels,
                                                     input int frac);
    logic [SCREEN_W-1:0] p;
    logic [LIM_W-1:0]    lv;
    p  = (pixels == '0) ? SCREEN_W'(1) : pixels;
    lv = LIM_W'(p - SCREEN_W'(1)) << frac;
    if (lv > LIM_W'(32767)) return LIGHT_W'(32767);
    return lv[LIGHT_W-1:0];
  endfunction

endpackage

/* hw/rtl/closest_ray_segment_hit.sv */
// ----------------------------------------------------------------------------
// closest_ray_segment_hit
// Nearest ray/segment intersection over a run of wall segments.
// ----------------------------------------------------------------------------
// Usage: write light_x, light_y, screen_width, screen_height through the
// cfg_we / cfg_index / cfg_data port while idle. Each input request carries
// the ray target and one segment; last_segment closes a query and produces
// one result request (nearest clamped hit, or the target with was_hit low).
// The front computes determinants in three pipeline stages and parks
// classified segments in a two-entry queue, so it keeps taking requests
// while the back works. The back spends longer on a hit segment than on a
// missed one, as its shared bit-serial divider takes 54 steps for each of x
// and y; the result is registered in the emit state after the last segment.
// The result sits in an output register: a stalled receiver holds it and,
// once the queue fills, in_ready drops. Reset clears the queue, the query
// state and the result valid, and loads the register reset values.
// ----------------------------------------------------------------------------
module closest_ray_segment_hit #(
  parameter int COORD_FRAC_BITS = crsh_pkg::COORD_FRAC_BITS
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [crsh_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [crsh_pkg::CFG_DATA_W-1:0]      cfg_data,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [crsh_pkg::COORD_W-1:0]  target_x,
  input  logic signed [crsh_pkg::COORD_W-1:0]  target_y,
  input  logic signed [crsh_pkg::COORD_W-1:0]  seg_ax,
  input  logic signed [crsh_pkg::COORD_W-1:0]  seg_ay,
  input  logic signed [crsh_pkg::COORD_W-1:0]  seg_bx,
  input  logic signed [crsh_pkg::COORD_W-1:0]  seg_by,
  input  logic                                 last_segment,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [crsh_pkg::COORD_W-1:0]  hit_x,
  output logic signed [crsh_pkg::COORD_W-1:0]  hit_y,
  output logic                                 was_hit
);

  logic [crsh_pkg::LIGHT_W-1:0]  light_x, light_y;
  logic [crsh_pkg::SCREEN_W-1:0] screen_width, screen_height;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      light_x       <= '0;
      light_y       <= '0;
      screen_width  <= crsh_pkg::SCREEN_W'(800);
      screen_height <= crsh_pkg::SCREEN_W'(600);
    end else if (cfg_we) begin
      case (cfg_index)
        crsh_pkg::REG_LIGHT_X:       light_x       <= cfg_data;
        crsh_pkg::REG_LIGHT_Y:       light_y       <= cfg_data;
        crsh_pkg::REG_SCREEN_WIDTH:  screen_width  <= cfg_data[crsh_pkg::SCREEN_W-1:0];
        crsh_pkg::REG_SCREEN_HEIGHT: screen_height <= cfg_data[crsh_pkg::SCREEN_W-1:0];
        default: ;
      endcase
    end
  end

  logic                 push, pop;
  crsh_pkg::seg_entry_t push_data, head;
  crsh_pkg::q_stat_t    q_stat;

  crsh_front u_front (
    .clk, .rst, .light_x, .light_y, .in_valid, .in_ready,
    .target_x, .target_y, .seg_ax, .seg_ay, .seg_bx, .seg_by, .last_segment,
    .push, .push_data, .q_stat
  );

  crsh_queue u_queue (
    .clk, .rst, .push, .push_data, .pop, .head, .q_stat
  );

  crsh_back #(.FRAC_BITS(COORD_FRAC_BITS)) u_back (
    .clk, .rst, .light_x, .light_y, .screen_width, .screen_height,
    .head, .q_stat, .pop, .out_valid, .out_ready, .hit_x, .hit_y, .was_hit
  );

  // back only pops a queued segment
  a_pop_valid: assert property (@(posedge clk) disable iff (rst) pop |-> q_stat.valid)
    else $error("pop from empty queue");

  // front never writes into a full queue
  a_push_room: assert property (@(posedge clk) disable iff (rst) push |-> !q_stat.full)
    else $error("push into full queue");

  // queue cannot be full and empty at once
  a_q_stat: assert property (@(posedge clk) disable iff (rst) !(q_stat.full && !q_stat.valid))
    else $error("queue status inconsistent");

endmodule

/* hw/rtl/crsh_front.sv */
// ----------------------------------------------------------------------------
// crsh_front
// Takes segment requests, forms the ray/segment determinants and classifies
// each segment as hit or miss; two register stages ahead of the queue.
// ----------------------------------------------------------------------------
module crsh_front (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic [crsh_pkg::LIGHT_W-1:0]          light_x,
  input  logic [crsh_pkg::LIGHT_W-1:0]          light_y,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [crsh_pkg::COORD_W-1:0]   target_x,
  input  logic signed [crsh_pkg::COORD_W-1:0]   target_y,
  input  logic signed [crsh_pkg::COORD_W-1:0]   seg_ax,
  input  logic signed [crsh_pkg::COORD_W-1:0]   seg_ay,
  input  logic signed [crsh_pkg::COORD_W-1:0]   seg_bx,
  input  logic signed [crsh_pkg::COORD_W-1:0]   seg_by,
  input  logic                                  last_segment,
  output logic                                  push,
  output crsh_pkg::seg_entry_t                  push_data,
  input  crsh_pkg::q_stat_t                     q_stat
);

  localparam int DW = crsh_pkg::DIFF_W;
  localparam int PW = crsh_pkg::PROD_W;
  localparam int SW = crsh_pkg::SUM_W;

  // stage 0: differences
  logic                 s0_valid;
  logic signed [DW-1:0] v1x, v1y, v2x, v2y, dx0, dy0;
  logic                 last0;
  logic signed [crsh_pkg::COORD_W-1:0] tx0, ty0;

  // stage 1: products
  logic                 s1_valid;
  logic signed [PW-1:0] p_da, p_db, p_1a, p_1b, p_2a, p_2b;
  logic signed [DW-1:0] dx1, dy1;
  logic                 last1;
  logic signed [crsh_pkg::COORD_W-1:0] tx1, ty1;

  logic advance;
  logic signed [DW-1:0] pxs, pys;

  assign advance  = !(s1_valid && q_stat.full);
  assign in_ready = advance;
  assign pxs      = $signed({2'b00, light_x});
  assign pys      = $signed({2'b00, light_y});

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
      s1_valid <= 1'b0;
    end else if (advance) begin
      s0_valid <= in_valid;
      s1_valid <= s0_valid;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (advance) begin
      v1x   <= pxs - DW'(seg_ax);
      v1y   <= pys - DW'(seg_ay);
      v2x   <= DW'(seg_bx) - DW'(seg_ax);
      v2y   <= DW'(seg_by) - DW'(seg_ay);
      dx0   <= DW'(target_x) - pxs;
      dy0   <= DW'(target_y) - pys;
      last0 <= last_segment;
      tx0   <= target_x;
      ty0   <= target_y;

      p_da  <= PW'(v2x) * PW'(-dy0);
      p_db  <= PW'(v2y) * PW'(dx0);
      p_1a  <= PW'(v2x) * PW'(v1y);
      p_1b  <= PW'(v2y) * PW'(v1x);
      p_2a  <= PW'(v1x) * PW'(-dy0);
      p_2b  <= PW'(v1y) * PW'(dx0);
      dx1   <= dx0;
      dy1   <= dy0;
      last1 <= last0;
      tx1   <= tx0;
      ty1   <= ty0;
    end
  end

  // stage 2: sums, sign fix, hit test
  logic signed [SW-1:0] den_s, n1_s, n2_s, den_p, n1_p, n2_p;

  always_comb begin
    den_s = SW'(p_da) + SW'(p_db);
    n1_s  = SW'(p_1a) - SW'(p_1b);
    n2_s  = SW'(p_2a) + SW'(p_2b);
    if (den_s < 0) begin
      den_p = -den_s;
      n1_p  = -n1_s;
      n2_p  = -n2_s;
    end else begin
      den_p = den_s;
      n1_p  = n1_s;
      n2_p  = n2_s;
    end
    push_data.hit  = (den_s != '0) && (n1_p >= 0) && (n2_p >= 0) && (n2_p <= den_p);
    push_data.last = last1;
    push_data.num1 = n1_p;
    push_data.den  = den_p;
    push_data.dx   = dx1;
    push_data.dy   = dy1;
    push_data.tx   = tx1;
    push_data.ty   = ty1;
  end

  assign push = s1_valid && !q_stat.full;

endmodule

/* hw/rtl/crsh_queue.sv */
// ----------------------------------------------------------------------------
// crsh_queue
// Two-entry queue of classified segments between front and back.
// ----------------------------------------------------------------------------
module crsh_queue (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  crsh_pkg::seg_entry_t push_data,
  input  logic                 pop,
  output crsh_pkg::seg_entry_t head,
  output crsh_pkg::q_stat_t    q_stat
);

  crsh_pkg::seg_entry_t slots [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= !wr_ptr;
      if (pop)  rd_ptr <= !rd_ptr;
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= push_data;
  end

  assign head         = slots[rd_ptr];
  assign q_stat.valid = (count != 2'd0);
  assign q_stat.full  = (count == 2'd2);

endmodule

/* hw/rtl/crsh_back.sv */
// ----------------------------------------------------------------------------
// crsh_back
// Computes the hit point of each hit segment with a shared bit-serial
// divider, clamps it, keeps the nearest one and emits the query result.
// ----------------------------------------------------------------------------
module crsh_back #(
  parameter int FRAC_BITS = crsh_pkg::COORD_FRAC_BITS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic [crsh_pkg::LIGHT_W-1:0]        light_x,
  input  logic [crsh_pkg::LIGHT_W-1:0]        light_y,
  input  logic [crsh_pkg::SCREEN_W-1:0]       screen_width,
  input  logic [crsh_pkg::SCREEN_W-1:0]       screen_height,
  input  crsh_pkg::seg_entry_t                head,
  input  crsh_pkg::q_stat_t                   q_stat,
  output logic                                pop,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [crsh_pkg::COORD_W-1:0] hit_x,
  output logic signed [crsh_pkg::COORD_W-1:0] hit_y,
  output logic                                was_hit
);

  localparam int NW = crsh_pkg::DIV_N_W;
  localparam int DW = crsh_pkg::DIV_D_W;
  localparam int QW = crsh_pkg::QSAT_W;
  localparam int LW = crsh_pkg::LIGHT_W;
  localparam int EW = crsh_pkg::DIFF_W;
  localparam logic [crsh_pkg::DIV_CNT_W-1:0] LAST_STEP = crsh_pkg::DIV_CNT_W'(NW - 1);

  crsh_pkg::back_state_t state, state_next;
  crsh_pkg::seg_entry_t  ent;

  logic                 can_emit, div_last;
  logic [DW-1:0]        div_rem;
  logic [NW-1:0]        div_q;
  logic                 div_neg;
  logic [crsh_pkg::DIV_CNT_W-1:0] div_cnt;
  logic signed [QW:0]   qx, qy;
  logic [LW-1:0]        hx, hy, best_x, best_y;
  logic signed [EW-1:0] ex, ey;
  logic [2*EW-1:0]      sqx, sqy;
  logic [crsh_pkg::DIST_W-1:0] best_dist, hit_dist;
  logic                 have_best;

  assign can_emit = !out_valid || out_ready;
  assign div_last = (div_cnt == LAST_STEP);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      crsh_pkg::B_IDLE:
        if (q_stat.valid) state_next = head.hit ? crsh_pkg::B_MULX : crsh_pkg::B_UPDATE;
      crsh_pkg::B_MULX:   state_next = crsh_pkg::B_DIVX;
      crsh_pkg::B_DIVX:   if (div_last) state_next = crsh_pkg::B_MULY;
      crsh_pkg::B_MULY:   state_next = crsh_pkg::B_DIVY;
      crsh_pkg::B_DIVY:   if (div_last) state_next = crsh_pkg::B_CLAMP;
      crsh_pkg::B_CLAMP:  state_next = crsh_pkg::B_SQUARE;
      crsh_pkg::B_SQUARE: state_next = crsh_pkg::B_UPDATE;
      crsh_pkg::B_UPDATE: state_next = ent.last ? crsh_pkg::B_EMIT : crsh_pkg::B_IDLE;
      crsh_pkg::B_EMIT:   if (can_emit) state_next = crsh_pkg::B_IDLE;
      default:            state_next = crsh_pkg::B_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    pop = 1'b0;
    unique case (state)
      crsh_pkg::B_IDLE: pop = q_stat.valid;
      default:          pop = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= crsh_pkg::B_IDLE;
    else     state <= state_next;
  end

  // numerator 2*num1*d + den for the axis in work
  logic signed [NW:0]   numer;
  logic signed [EW-1:0] mul_d;
  logic [NW-1:0]        numer_mag;
  always_comb begin
    mul_d     = (state == crsh_pkg::B_MULY) ? ent.dy : ent.dx;
    numer     = ((NW+1)'($signed({1'b0, ent.num1})) * (NW+1)'(mul_d) <<< 1)
                + (NW+1)'($signed({1'b0, ent.den}));
    numer_mag = numer[NW] ? NW'(-numer) : NW'(numer);
  end

  // one restoring division step
  logic [DW:0]   rem_sh;
  logic          ge;
  logic [DW-1:0] rem_new;
  logic [NW-1:0] q_new;
  always_comb begin
    rem_sh  = {div_rem, div_q[NW-1]};
    ge      = (rem_sh >= {1'b0, ent.den, 1'b0});
    rem_new = ge ? DW'(rem_sh - {1'b0, ent.den, 1'b0}) : rem_sh[DW-1:0];
    q_new   = {div_q[NW-2:0], ge};
  end

  // floor quotient, saturated to the range that can still land on screen
  logic [NW-1:0]      q_adj;
  logic [QW-1:0]      q_sat;
  logic signed [QW:0] q_fin;
  always_comb begin
    q_adj = q_new + NW'(div_neg && (rem_new != '0));
    q_sat = (q_adj >= NW'(1 << (QW - 1))) ? QW'(1 << (QW - 1)) : q_adj[QW-1:0];
    q_fin = div_neg ? -$signed({1'b0, q_sat}) : $signed({1'b0, q_sat});
  end

  // hit point clamp to the screen
  logic [LW-1:0] lim_x, lim_y, hx_c, hy_c;
  logic signed [QW+1:0] sx, sy;
  always_comb begin
    lim_x = crsh_pkg::screen_limit(screen_width, FRAC_BITS);
    lim_y = crsh_pkg::screen_limit(screen_height, FRAC_BITS);
    sx    = $signed({5'b00000, light_x}) + (QW+2)'(qx);
    sy    = $signed({5'b00000, light_y}) + (QW+2)'(qy);
    if (sx < 0)                            hx_c = '0;
    else if (sx > $signed({5'b0, lim_x}))  hx_c = lim_x;
    else                                   hx_c = sx[LW-1:0];
    if (sy < 0)                            hy_c = '0;
    else if (sy > $signed({5'b0, lim_y}))  hy_c = lim_y;
    else                                   hy_c = sy[LW-1:0];
  end

  assign hit_dist = crsh_pkg::DIST_W'(sqx) + crsh_pkg::DIST_W'(sqy);

  // datapath
  always_ff @(posedge clk) begin
    if (pop) ent <= head;
    if (state == crsh_pkg::B_MULX || state == crsh_pkg::B_MULY) begin
      div_q   <= numer_mag;
      div_rem <= '0;
      div_neg <= numer[NW];
      div_cnt <= '0;
    end
    if (state == crsh_pkg::B_DIVX || state == crsh_pkg::B_DIVY) begin
      div_q   <= q_new;
      div_rem <= rem_new;
      div_cnt <= div_cnt + 1'b1;
    end
    if (state == crsh_pkg::B_DIVX && div_last) qx <= q_fin;
    if (state == crsh_pkg::B_DIVY && div_last) qy <= q_fin;
    if (state == crsh_pkg::B_CLAMP) begin
      hx <= hx_c;
      hy <= hy_c;
      ex <= $signed({2'b00, hx_c}) - $signed({2'b00, light_x});
      ey <= $signed({2'b00, hy_c}) - $signed({2'b00, light_y});
    end
    if (state == crsh_pkg::B_SQUARE) begin
      sqx <= (2*EW)'(ex * ex);
      sqy <= (2*EW)'(ey * ey);
    end
  end

  // running nearest hit and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      have_best <= 1'b0;
      best_x    <= '0;
      best_y    <= '0;
      best_dist <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_valid && out_ready) out_valid <= 1'b0;
      if (state == crsh_pkg::B_UPDATE && ent.hit && (!have_best || hit_dist < best_dist)) begin
        have_best <= 1'b1;
        best_x    <= hx;
        best_y    <= hy;
        best_dist <= hit_dist;
      end
      if (state == crsh_pkg::B_EMIT && can_emit) begin
        out_valid <= 1'b1;
        have_best <= 1'b0;
        best_x    <= '0;
        best_y    <= '0;
        best_dist <= '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == crsh_pkg::B_EMIT && can_emit) begin
      hit_x   <= have_best ? $signed({1'b0, best_x}) : ent.tx;
      hit_y   <= have_best ? $signed({1'b0, best_y}) : ent.ty;
      was_hit <= have_best;
    end
  end

endmodule
